[hw/rtl/smsu_pkg.sv]
`default_nettype none

package smsu_pkg;

	localparam int unsigned WORD_BITS = 8;
	localparam int unsigned CNT_W     = $clog2(WORD_BITS);
	localparam int unsigned PIN_W     = 3;
	localparam int unsigned REG_IDX_W = 3;

	typedef enum logic [1:0] {
		OP_MOSI   = 2'd0,
		OP_CLOCK  = 2'd1,
		OP_SELECT = 2'd2,
		OP_READ   = 2'd3
	} smsu_op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SELECT_PIN   = 3'd0,
		REG_CLOCK_PIN    = 3'd1,
		REG_SDI_PIN      = 3'd2,
		REG_SDO_PIN      = 3'd3,
		REG_BYTE_REPLY   = 3'd4,
		REG_SELECT_REPLY = 3'd5
	} smsu_reg_t;

	typedef struct packed {
		smsu_op_t             operation;
		logic [WORD_BITS-1:0] port_data;
		logic [WORD_BITS-1:0] reply_byte;
	} smsu_item_t;

	typedef struct packed {
		logic                 byte_done;
		logic [WORD_BITS-1:0] received_byte;
		logic                 select_changed;
		logic                 select_active;
		logic [WORD_BITS-1:0] miso_read_data;
	} smsu_result_t;

	typedef struct packed {
		logic [PIN_W-1:0] select_pin;
		logic [PIN_W-1:0] clock_pin;
		logic [PIN_W-1:0] sdi_pin;
		logic [PIN_W-1:0] sdo_pin;
		logic             byte_reply_enable;
		logic             select_reply_enable;
	} smsu_cfg_t;

	// classified request handed from front to back
	typedef struct packed {
		smsu_op_t             op;
		logic                 level;
		logic [WORD_BITS-1:0] load_byte;
		logic [PIN_W-1:0]     read_pin;
	} smsu_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/smsu_fifo.sv]
`default_nettype none

module smsu_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_pop_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop without push did not drop the count");

endmodule

`default_nettype wire

[hw/rtl/smsu_front.sv]
`default_nettype none

module smsu_front import smsu_pkg::*; (
	input  wire smsu_item_t item,
	input  wire smsu_cfg_t  cfg,
	output smsu_cmd_t       cmd
);

	logic [PIN_W-1:0] pin;

	// pick the port bit that this request looks at
	always_comb begin
		unique case (item.operation)
			OP_MOSI:   pin = cfg.sdi_pin;
			OP_CLOCK:  pin = cfg.clock_pin;
			OP_SELECT: pin = cfg.select_pin;
			OP_READ:   pin = cfg.sdo_pin;
			default:   pin = cfg.sdo_pin;
		endcase
	end

	always_comb begin
		cmd.op       = item.operation;
		cmd.level    = item.port_data[pin];
		cmd.read_pin = cfg.sdo_pin;
		// resolve the reply source now, so the back end only loads it
		if (item.operation == OP_SELECT) begin
			cmd.load_byte = cfg.select_reply_enable ? item.reply_byte : '1;
		end else begin
			cmd.load_byte = cfg.byte_reply_enable ? item.reply_byte : '1;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/smsu_back.sv]
`default_nettype none

module smsu_back import smsu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire smsu_cmd_t cmd,
	input  wire logic      cmd_empty,
	output logic           cmd_pop,
	input  wire logic      res_full,
	output logic           res_push,
	output smsu_result_t   res
);

	logic                 last_clk_q, last_sel_q, mosi_q, miso_q;
	logic [WORD_BITS-1:0] rx_q, tx_q;
	logic [CNT_W-1:0]     cnt_q;

	logic                 last_clk_d, last_sel_d, mosi_d, miso_d;
	logic [WORD_BITS-1:0] rx_d, tx_d;
	logic [CNT_W-1:0]     cnt_d;

	assign res_push = !cmd_empty && !res_full;
	assign cmd_pop  = res_push;

	always_comb begin
		last_clk_d = last_clk_q;
		last_sel_d = last_sel_q;
		mosi_d     = mosi_q;
		miso_d     = miso_q;
		rx_d       = rx_q;
		tx_d       = tx_q;
		cnt_d      = cnt_q;
		res        = '0;
		unique case (cmd.op)
			OP_MOSI: begin
				mosi_d = cmd.level;
			end
			OP_CLOCK: begin
				if (cmd.level != last_clk_q) begin
					last_clk_d = cmd.level;
					if (cmd.level) begin
						rx_d = {rx_q[WORD_BITS-2:0], mosi_q};
						if (cnt_q == CNT_W'(WORD_BITS - 1)) begin
							cnt_d             = '0;
							res.byte_done     = 1'b1;
							res.received_byte = rx_d;
							tx_d              = cmd.load_byte;
						end else begin
							cnt_d = cnt_q + 1'b1;
						end
					end else begin
						// falling edge: present MSB, advance the reply
						miso_d = tx_q[WORD_BITS-1];
						tx_d   = {tx_q[WORD_BITS-2:0], 1'b0};
					end
				end
			end
			OP_SELECT: begin
				if (cmd.level != last_sel_q) begin
					last_sel_d         = cmd.level;
					res.select_changed = 1'b1;
					res.select_active  = !cmd.level;
					tx_d               = cmd.load_byte;
					miso_d             = cmd.load_byte[WORD_BITS-1];
					cnt_d              = '0;
				end
			end
			OP_READ: begin
				res.miso_read_data = {{(WORD_BITS-1){1'b0}}, miso_q} << cmd.read_pin;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_clk_q <= 1'b0;
			last_sel_q <= 1'b1;
			mosi_q     <= 1'b0;
			miso_q     <= 1'b0;
			rx_q       <= '0;
			tx_q       <= '0;
			cnt_q      <= '0;
		end else if (res_push) begin
			last_clk_q <= last_clk_d;
			last_sel_q <= last_sel_d;
			mosi_q     <= mosi_d;
			miso_q     <= miso_d;
			rx_q       <= rx_d;
			tx_q       <= tx_d;
			cnt_q      <= cnt_d;
		end
	end

	a_done_clears_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.byte_done) |=> (cnt_q == '0))
		else $error("bit count not cleared after byte");

	a_sel_clears_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.select_changed) |=>
			(cnt_q == '0 && last_sel_q == !$past(res.select_active)))
		else $error("select change not applied");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !(res.byte_done && res.select_changed))
		else $error("byte and select events in one result");

endmodule

`default_nettype wire

[hw/rtl/spi_mode0_subordinate_unit.sv]
// Requests pass through the request queue to the back end, which updates the SPI state
// once per request, one request per cycle while the result queue has room.
// Two short queues, request side and result side, let each side stall on its own.
// Reset (arst_n low, asynchronous) restores the pin and reply registers to defaults,
// empties both queues and returns the shift state to idle with select inactive.
`default_nettype none

module spi_mode0_subordinate_unit import smsu_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire smsu_item_t   item,
	output logic              empty,
	input  wire logic         pop,
	output smsu_result_t      result,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	smsu_cfg_t    cfg_q;
	smsu_cmd_t    cmd_in, cmd_out;
	smsu_result_t res;
	smsu_reg_t    reg_idx;
	logic         cmd_empty, cmd_pop, res_full, res_push;

	assign pready  = 1'b1;
	assign reg_idx = smsu_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.select_pin          <= PIN_W'(0);
			cfg_q.clock_pin           <= PIN_W'(1);
			cfg_q.sdi_pin             <= PIN_W'(2);
			cfg_q.sdo_pin             <= PIN_W'(3);
			cfg_q.byte_reply_enable   <= 1'b1;
			cfg_q.select_reply_enable <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_SELECT_PIN:   cfg_q.select_pin          <= pwdata[PIN_W-1:0];
				REG_CLOCK_PIN:    cfg_q.clock_pin           <= pwdata[PIN_W-1:0];
				REG_SDI_PIN:      cfg_q.sdi_pin             <= pwdata[PIN_W-1:0];
				REG_SDO_PIN:      cfg_q.sdo_pin             <= pwdata[PIN_W-1:0];
				REG_BYTE_REPLY:   cfg_q.byte_reply_enable   <= pwdata[0];
				REG_SELECT_REPLY: cfg_q.select_reply_enable <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SELECT_PIN:   prdata = {{(32-PIN_W){1'b0}}, cfg_q.select_pin};
			REG_CLOCK_PIN:    prdata = {{(32-PIN_W){1'b0}}, cfg_q.clock_pin};
			REG_SDI_PIN:      prdata = {{(32-PIN_W){1'b0}}, cfg_q.sdi_pin};
			REG_SDO_PIN:      prdata = {{(32-PIN_W){1'b0}}, cfg_q.sdo_pin};
			REG_BYTE_REPLY:   prdata = {31'b0, cfg_q.byte_reply_enable};
			REG_SELECT_REPLY: prdata = {31'b0, cfg_q.select_reply_enable};
			default:          prdata = '0;
		endcase
	end

	smsu_front u_front (
		.item (item),
		.cfg  (cfg_q),
		.cmd  (cmd_in)
	);

	smsu_fifo #(
		.WIDTH ($bits(smsu_cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	smsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	smsu_fifo #(
		.WIDTH ($bits(smsu_result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

endmodule

`default_nettype wire
